@@ rtl/jcrd_pkg.sv @@
// Shared types and helpers for the JPEG coefficient run-length and DC prediction decoder.
// Used by the front classifier, the queue, the back end and the top level. No dependencies.
package jcrd_pkg;

   localparam int NUM_COMPONENTS_DEFAULT = 3;
   localparam int QUEUE_DEPTH            = 2;

   localparam logic [7:0] SYM_EOB     = 8'h00;
   localparam logic [7:0] SYM_ZRL     = 8'hF0;
   localparam logic [7:0] RUN_MASK    = 8'hF0;
   localparam logic [7:0] SIZE_MASK   = 8'h0F;
   localparam logic [3:0] ZRL_SPAN    = 4'd15;
   localparam logic [7:0] DC_SIZE_MAX = 8'd11;
   localparam logic [3:0] AC_SIZE_MAX = 4'd10;
   localparam logic [6:0] LAST_POS    = 7'd63;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_DC,
      OP_AC
   } op_type;

   typedef struct packed {
      logic [1:0]  component;
      logic [7:0]  symbol;
      logic [10:0] extra_bits;
   } req_type;

   typedef struct packed {
      logic [5:0]         coeff_position;
      logic signed [15:0] coeff_value;
      logic               write_valid;
      logic               block_end;
      logic               format_error;
   } rsp_type;

   // One classified item as handed from the front to the back.
   typedef struct packed {
      op_type      op;
      logic [1:0]  component;
      logic [3:0]  size;
      logic [10:0] extra_bits;
      logic [5:0]  coeff_position;
      logic        block_end;
      logic        format_error;
   } entry_type;

   // JPEG sign extension of a size-bit magnitude (size 0..11).
   function automatic logic [15:0] extend_magnitude(input logic [3:0] size,
                                                    input logic [10:0] bits);
      logic [11:0] full;
      logic [11:0] mask;
      logic [15:0] value;
      full  = 12'd1 << size;
      mask  = full - 12'd1;
      value = {5'd0, bits & mask[10:0]};
      if (size != 4'd0 && !bits[size - 4'd1]) begin
         value = value - {4'd0, mask};
      end
      return value;
   endfunction

endpackage

@@ rtl/jcrd_front.sv @@
// Front end: tracks the block position, classifies each symbol and computes where it lands.
// Depends on jcrd_pkg.
module jcrd_front import jcrd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      take,
   input  req_type   req_data,
   output entry_type entry
);

   logic [5:0] pos_ff;
   logic [5:0] pos_in;
   logic [6:0] next_pos;
   logic [6:0] target;
   logic [3:0] run;
   logic [3:0] size;
   logic       eob;

   assign run    = 4'((req_data.symbol & RUN_MASK) >> 4);
   assign size   = 4'(req_data.symbol & SIZE_MASK);
   assign target = {1'b0, pos_ff} + {3'd0, run};

   always_comb begin
      entry.op             = OP_NONE;
      entry.component      = req_data.component;
      entry.size           = size;
      entry.extra_bits     = req_data.extra_bits;
      entry.coeff_position = 6'd0;
      entry.format_error   = 1'b0;
      eob                  = 1'b0;
      next_pos             = {1'b0, pos_ff} + 7'd1;
      if (pos_ff == 6'd0) begin
         if (req_data.symbol > DC_SIZE_MAX) begin
            entry.format_error = 1'b1;
         end else begin
            entry.op = OP_DC;
         end
      end else if (req_data.symbol == SYM_EOB) begin
         eob = 1'b1;
      end else if (req_data.symbol == SYM_ZRL) begin
         if ({1'b0, pos_ff} + {3'd0, ZRL_SPAN} > LAST_POS) begin
            entry.format_error = 1'b1;
         end else begin
            next_pos = {1'b0, pos_ff} + {3'd0, ZRL_SPAN} + 7'd1;
         end
      end else if (size == 4'd0 || size > AC_SIZE_MAX) begin
         entry.format_error = 1'b1;
      end else if (target > LAST_POS) begin
         entry.format_error = 1'b1;
      end else begin
         entry.op             = OP_AC;
         entry.coeff_position = target[5:0];
         next_pos             = target + 7'd1;
      end
      // A position of 64 closes the block just as an end-of-block symbol does.
      entry.block_end = eob | next_pos[6];
      pos_in          = (eob | next_pos[6]) ? 6'd0 : next_pos[5:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 6'd0;
      end else if (take) begin
         pos_ff <= pos_in;
      end
   end

endmodule

@@ rtl/jcrd_queue.sv @@
// Short first-in first-out queue of classified items between front and back.
// Depends on jcrd_pkg.
module jcrd_queue import jcrd_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   output logic      full,
   input  logic      pop,
   output logic      not_empty,
   output entry_type pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

@@ rtl/jcrd_back.sv @@
// Back end: sign-extends magnitudes, applies DC prediction and holds the result register.
// Depends on jcrd_pkg.
module jcrd_back import jcrd_pkg::*; #(
   parameter int NUM_COMPONENTS = NUM_COMPONENTS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      entry_valid,
   input  entry_type entry,
   output logic      entry_pop,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output rsp_type   rsp_data
);

   localparam int IDX_W = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1;

   logic [15:0] pred_ff [NUM_COMPONENTS];
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;
   rsp_type     rsp_data_in;
   logic [15:0] magnitude;
   logic [15:0] pred;
   logic [15:0] dc_sum;
   logic        comp_known;
   logic [IDX_W-1:0] comp_idx;

   assign entry_pop  = entry_valid && (!rsp_valid_ff || rsp_ready);
   assign comp_known = ({30'd0, entry.component} < 32'(NUM_COMPONENTS));
   assign comp_idx   = IDX_W'(entry.component);
   assign magnitude  = extend_magnitude(entry.size, entry.extra_bits);
   // An unknown component is predicted from zero and leaves no predictor behind.
   assign pred       = comp_known ? pred_ff[comp_idx] : 16'd0;
   assign dc_sum     = magnitude + pred;

   always_comb begin
      rsp_data_in.coeff_position = entry.coeff_position;
      rsp_data_in.block_end      = entry.block_end;
      rsp_data_in.format_error   = entry.format_error;
      case (entry.op)
         OP_DC: begin
            rsp_data_in.coeff_value = dc_sum;
            rsp_data_in.write_valid = 1'b1;
         end
         OP_AC: begin
            rsp_data_in.coeff_value = magnitude;
            rsp_data_in.write_valid = 1'b1;
         end
         default: begin
            rsp_data_in.coeff_value = 16'sd0;
            rsp_data_in.write_valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_COMPONENTS; i++) begin
            pred_ff[i] <= 16'd0;
         end
      end else if (entry_pop && entry.op == OP_DC && comp_known) begin
         pred_ff[comp_idx] <= dc_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (entry_pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (entry_pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ rtl/jpeg_coefficient_rle_dpcm_decode.sv @@
// JPEG baseline run-length expansion and DC prediction decoder, top level.
// The block takes one Huffman-decoded symbol beat per clock while req_ready is high and gives
// exactly one result beat for each: the coefficient write (zigzag position and value, DC with
// its prediction added), an end-of-block flag and a format error flag. Throughput is one beat
// per cycle while the output is not stalled; each input beat is written into the queue and
// then into the result register, from which it is presented, and the two-entry queue between
// the position tracker and the value path absorbs output stalls.
// Depends on jcrd_pkg, jcrd_front, jcrd_queue and jcrd_back.
module jpeg_coefficient_rle_dpcm_decode import jcrd_pkg::*; #(
   parameter int NUM_COMPONENTS = NUM_COMPONENTS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   entry_type front_entry;
   entry_type queue_entry;
   logic      queue_full;
   logic      queue_not_empty;
   logic      queue_pop;
   logic      take;

   assign req_ready = !queue_full;
   assign take      = req_valid && req_ready;

   jcrd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .req_data (req_data),
      .entry    (front_entry)
   );

   jcrd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (take),
      .push_data (front_entry),
      .full      (queue_full),
      .pop       (queue_pop),
      .not_empty (queue_not_empty),
      .pop_data  (queue_entry)
   );

   jcrd_back #(
      .NUM_COMPONENTS (NUM_COMPONENTS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .entry_valid (queue_not_empty),
      .entry       (queue_entry),
      .entry_pop   (queue_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule
